>>> sv/ffca_pkg.sv
package ffca_pkg;

  localparam int unsigned AMOUNT_BITS = 30;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned OUT_INDEX_W = 10;
  localparam int unsigned MISS_W      = 10;
  localparam logic [MISS_W-1:0] MISS_MAX = {MISS_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_PLACE   = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e;

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic [AMOUNT_BITS-1:0] amount;
  } ffca_in_t;

  typedef struct packed {
    logic                   placed;
    logic [OUT_INDEX_W-1:0] bin_index;
    logic [MISS_W-1:0]      unplaced_total;
  } ffca_out_t;

  // Operation token travelling down the cell chain.
  typedef struct packed {
    logic                   valid;
    logic [FUNC_W-1:0]      func;
    logic [AMOUNT_BITS-1:0] amount;
    logic                   hit;
  } ffca_op_t;

endpackage

>>> sv/ffca_cell.sv
module ffca_cell #(
  parameter int unsigned IDX_W      = 10,
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  ffca_pkg::ffca_op_t  op_i,
  input  logic [IDX_W-1:0]    idx_i,
  output ffca_pkg::ffca_op_t  op_o,
  output logic [IDX_W-1:0]    idx_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

  logic [ffca_pkg::AMOUNT_BITS-1:0] cap_q, cap_d;
  logic                             loaded_q, loaded_d;
  logic                             used_q, used_d;
  ffca_pkg::ffca_op_t               op_q, op_d;
  logic [IDX_W-1:0]                 idx_q, idx_d;
  logic                             fits;

  assign fits = loaded_q && !used_q && !op_i.hit && (cap_q >= op_i.amount);

  always_comb begin
    op_d     = op_i;
    idx_d    = idx_i;
    cap_d    = cap_q;
    loaded_d = loaded_q;
    used_d   = used_q;
    if (op_i.valid) begin
      priority if (op_i.func == ffca_pkg::FUNC_LOAD) begin
        if (idx_i == MY_IDX) begin
          cap_d    = op_i.amount;
          loaded_d = 1'b1;
          used_d   = 1'b0;
        end
      end else if (op_i.func == ffca_pkg::FUNC_RESTART) begin
        loaded_d = 1'b0;
        used_d   = 1'b0;
      end else if (op_i.func == ffca_pkg::FUNC_PLACE) begin
        if (fits) begin
          used_d   = 1'b1;
          op_d.hit = 1'b1;
          idx_d    = MY_IDX;
        end
      end else begin
        op_d.valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= '0;
      loaded_q <= 1'b0;
      used_q   <= 1'b0;
    end else if (adv_i) begin
      op_q     <= op_d;
      loaded_q <= loaded_d;
      used_q   <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cap_q <= cap_d;
      idx_q <= idx_d;
    end
  end

  assign op_o  = op_q;
  assign idx_o = idx_q;

endmodule

>>> sv/first_fit_capacity_allocator_unit.sv
// First-fit bin allocator built as a chain of MAX_BINS cells, one bin per cell.
// Every accepted item (load, place, restart) enters cell 0 and moves one cell per
// cycle; a place request takes the first loaded, unused cell whose capacity is
// at least its demand. Results pass all cell registers and the output register;
// one item is accepted per cycle whenever the output is not stalled, so items
// overlap in the chain and keep their order. A stalled output freezes the whole
// chain. Loads beyond MAX_BINS and func 3 are dropped at entry; only place
// requests produce a result. Reset clears all used marks at once.
module first_fit_capacity_allocator_unit #(
  parameter int unsigned MAX_BINS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ffca_pkg::ffca_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ffca_pkg::ffca_out_t out_item_o
);

  localparam int unsigned IDX_W = $clog2(MAX_BINS);
  localparam int unsigned CNT_W = $clog2(MAX_BINS + 1);
  localparam int unsigned OUT_W = ffca_pkg::OUT_INDEX_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BINS);

  logic                        adv;
  logic [CNT_W-1:0]            bins_q, bins_d;
  logic [ffca_pkg::MISS_W-1:0] miss_q, miss_d;
  logic                        out_valid_q, out_valid_d;
  ffca_pkg::ffca_out_t         out_q, out_d;
  ffca_pkg::ffca_op_t          entry_op;
  logic [IDX_W-1:0]            entry_idx;
  ffca_pkg::ffca_op_t          link_op  [MAX_BINS+1];
  logic [IDX_W-1:0]            link_idx [MAX_BINS+1];
  ffca_pkg::ffca_op_t          tail;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    bins_d          = bins_q;
    entry_op.valid  = 1'b0;
    entry_op.func   = in_item_i.func;
    entry_op.amount = in_item_i.amount;
    entry_op.hit    = 1'b0;
    entry_idx       = '0;
    if (in_valid_i) begin
      priority if (in_item_i.func == ffca_pkg::FUNC_LOAD) begin
        if (bins_q != CNT_FULL) begin
          entry_op.valid = 1'b1;
          entry_idx      = bins_q[IDX_W-1:0];
          bins_d         = bins_q + CNT_W'(1);
        end
      end else if (in_item_i.func == ffca_pkg::FUNC_RESTART) begin
        entry_op.valid = 1'b1;
        bins_d         = '0;
      end else if (in_item_i.func == ffca_pkg::FUNC_PLACE) begin
        entry_op.valid = 1'b1;
      end else begin
        entry_op.valid = 1'b0;
      end
    end
  end

  assign link_op[0]  = entry_op;
  assign link_idx[0] = entry_idx;

  for (genvar j = 0; j < MAX_BINS; j++) begin : g_cell
    ffca_cell #(
      .IDX_W      (IDX_W),
      .CELL_INDEX (j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .op_i   (link_op[j]),
      .idx_i  (link_idx[j]),
      .op_o   (link_op[j+1]),
      .idx_o  (link_idx[j+1])
    );
  end

  assign tail = link_op[MAX_BINS];

  always_comb begin
    miss_d      = miss_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    if (tail.valid) begin
      if (tail.func == ffca_pkg::FUNC_RESTART) begin
        miss_d = '0;
      end else if (tail.func == ffca_pkg::FUNC_PLACE) begin
        if (!tail.hit && (miss_q != ffca_pkg::MISS_MAX)) begin
          miss_d = miss_q + ffca_pkg::MISS_W'(1);
        end
        out_valid_d          = 1'b1;
        out_d.placed         = tail.hit;
        out_d.bin_index      = OUT_W'(link_idx[MAX_BINS]);
        out_d.unplaced_total = miss_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q      <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      bins_q      <= bins_d;
      miss_q      <= miss_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> sv/ffca_checker.sv
module ffca_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input ffca_pkg::ffca_in_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ffca_pkg::ffca_out_t out_item_o
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.placed) |-> (out_item_o.bin_index == '0))
    else $error("bin index set on unplaced result");

  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall not tied to output backpressure");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_item_i)))
    else $error("stalled input item changed");

endmodule

bind first_fit_capacity_allocator_unit ffca_checker u_ffca_checker (.*);

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAXB = 1024;
  localparam logic [ffca_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam logic [ffca_pkg::AMOUNT_BITS-1:0] AMT_MAX = {ffca_pkg::AMOUNT_BITS{1'b1}};
  localparam int HOLD_CYC = 3000;
  localparam int RAND_ITEMS = 1050;

  typedef struct {
    ffca_pkg::ffca_in_t  item;
    bit                  typed;
    ffca_pkg::ffca_out_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  ffca_pkg::ffca_in_t  in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  ffca_pkg::ffca_out_t out_item_o;

  // predictor state
  logic [ffca_pkg::AMOUNT_BITS-1:0] bin_cap [MAXB];
  bit [MAXB-1:0]                    bin_taken;
  int                               bins_in;
  logic [ffca_pkg::MISS_W-1:0]      miss_tally;

  ffca_pkg::ffca_out_t alloc_q [$];
  ffca_pkg::ffca_out_t want;
  dir_row_t            dir_tab [$];
  int                  errors;
  int                  norm_cnt;
  int                  hold_left;
  bit                  calm;
  bit                  hold_req;
  bit                  hold_done;

  first_fit_capacity_allocator_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic predict_alloc(input ffca_pkg::ffca_in_t it, output bit got,
                               output ffca_pkg::ffca_out_t res);
    int hit_at;
    hit_at = -1;
    got = 1'b0;
    res = '0;
    case (it.func)
      ffca_pkg::FUNC_LOAD: begin
        if (bins_in < MAXB) begin
          bin_cap[bins_in] = it.amount;
          bin_taken[bins_in] = 1'b0;
          bins_in++;
        end
      end
      ffca_pkg::FUNC_RESTART: begin
        bin_taken = '0;
        bins_in = 0;
        miss_tally = '0;
      end
      ffca_pkg::FUNC_PLACE: begin
        for (int i = 0; i < bins_in; i++) begin
          if (!bin_taken[i] && bin_cap[i] >= it.amount) begin
            hit_at = i;
            break;
          end
        end
        got = 1'b1;
        if (hit_at >= 0) begin
          bin_taken[hit_at] = 1'b1;
          res.placed = 1'b1;
          res.bin_index = ffca_pkg::OUT_INDEX_W'(hit_at);
        end else if (miss_tally != ffca_pkg::MISS_MAX) begin
          miss_tally++;
        end
        res.unplaced_total = miss_tally;
      end
      default: ;
    endcase
  endtask

  // entered at a falling edge, returns at a falling edge
  task automatic offer_item(input ffca_pkg::ffca_in_t it, input bit typed,
                            input ffca_pkg::ffca_out_t typed_res);
    bit                  got;
    ffca_pkg::ffca_out_t res;
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    predict_alloc(it, got, res);
    if (got) alloc_q.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  task automatic drive(input logic [ffca_pkg::FUNC_W-1:0] f,
                       input logic [ffca_pkg::AMOUNT_BITS-1:0] a);
    ffca_pkg::ffca_in_t it;
    it.func = f;
    it.amount = a;
    offer_item(it, 1'b0, '0);
    if (f != FUNC_NONE) norm_cnt++;
    calm = (norm_cnt >= 400 && norm_cnt < 560);
    if (norm_cnt >= 150) hold_req = 1'b1;
  endtask

  function automatic logic [ffca_pkg::AMOUNT_BITS-1:0] rand_amt();
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k == 0) return '0;
    if (k == 1) return AMT_MAX;
    return ffca_pkg::AMOUNT_BITS'($urandom() >> $urandom_range(2, 31));
  endfunction

  function automatic dir_row_t row(input logic [ffca_pkg::FUNC_W-1:0] f,
                                   input logic [ffca_pkg::AMOUNT_BITS-1:0] a,
                                   input bit t = 1'b0, input logic p = 1'b0,
                                   input logic [ffca_pkg::OUT_INDEX_W-1:0] ix = '0,
                                   input logic [ffca_pkg::MISS_W-1:0] tot = '0);
    dir_row_t r;
    r.item.func = f;
    r.item.amount = a;
    r.typed = t;
    r.want.placed = p;
    r.want.bin_index = ix;
    r.want.unplaced_total = tot;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (alloc_q.size() == 0) begin
        report_err($sformatf("result with nothing pending: %p", out_item_o));
      end else begin
        want = alloc_q.pop_front();
        if (out_item_o.placed !== want.placed)
          report_err($sformatf("placed %b, want %b", out_item_o.placed, want.placed));
        if (out_item_o.bin_index !== want.bin_index)
          report_err($sformatf("bin_index %0d, want %0d",
                               out_item_o.bin_index, want.bin_index));
        if (out_item_o.unplaced_total !== want.unplaced_total)
          report_err($sformatf("unplaced_total %0d, want %0d",
                               out_item_o.unplaced_total, want.unplaced_total));
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYC;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (!calm && $urandom_range(0, 99) < 34);
      end
    end
  end

  initial begin
    #2000000;
    $display("first_fit_capacity_allocator_unit verification failed");
    $finish;
  end

  initial begin
    int  n;
    int  m;
    int  r;
    bit  fill_done;
    bit  sat_done;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    bin_taken  = '0;
    bins_in    = 0;
    miss_tally = '0;
    errors     = 0;
    norm_cnt   = 0;
    hold_left  = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    fill_done  = 1'b0;
    sat_done   = 1'b0;
    for (int i = 0; i < MAXB; i++) bin_cap[i] = '0;

    dir_tab.push_back(row(ffca_pkg::FUNC_PLACE,   '0,      1, 0, 0, 1));
    dir_tab.push_back(row(ffca_pkg::FUNC_PLACE,   AMT_MAX, 1, 0, 0, 2));
    dir_tab.push_back(row(FUNC_NONE,              AMT_MAX));
    dir_tab.push_back(row(ffca_pkg::FUNC_LOAD,    AMT_MAX));
    dir_tab.push_back(row(ffca_pkg::FUNC_LOAD,    '0));
    dir_tab.push_back(row(ffca_pkg::FUNC_LOAD,    30'd5));
    dir_tab.push_back(row(ffca_pkg::FUNC_PLACE,   AMT_MAX, 1, 1, 0, 2));
    dir_tab.push_back(row(ffca_pkg::FUNC_PLACE,   AMT_MAX, 1, 0, 0, 3));
    dir_tab.push_back(row(ffca_pkg::FUNC_PLACE,   '0,      1, 1, 1, 3));
    dir_tab.push_back(row(ffca_pkg::FUNC_PLACE,   30'd5,   1, 1, 2, 3));
    dir_tab.push_back(row(ffca_pkg::FUNC_PLACE,   '0,      1, 0, 0, 4));
    dir_tab.push_back(row(ffca_pkg::FUNC_LOAD,    30'd100));
    dir_tab.push_back(row(ffca_pkg::FUNC_LOAD,    30'd50));
    // first fit, not best fit
    dir_tab.push_back(row(ffca_pkg::FUNC_PLACE,   30'd50,  1, 1, 3, 4));
    dir_tab.push_back(row(ffca_pkg::FUNC_PLACE,   30'd60,  1, 0, 0, 5));
    dir_tab.push_back(row(ffca_pkg::FUNC_PLACE,   30'd50,  1, 1, 4, 5));
    dir_tab.push_back(row(ffca_pkg::FUNC_RESTART, AMT_MAX));
    dir_tab.push_back(row(ffca_pkg::FUNC_PLACE,   '0,      1, 0, 0, 1));
    dir_tab.push_back(row(ffca_pkg::FUNC_LOAD,    30'd1));
    dir_tab.push_back(row(ffca_pkg::FUNC_PLACE,   30'd1,   1, 1, 0, 1));
    dir_tab.push_back(row(FUNC_NONE,              '0));
    dir_tab.push_back(row(ffca_pkg::FUNC_PLACE,   30'd2,   1, 0, 0, 2));
    dir_tab.push_back(row(ffca_pkg::FUNC_RESTART, '0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) offer_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

    while (norm_cnt < RAND_ITEMS) begin
      if (norm_cnt >= 300 && !fill_done) begin
        // fill the table, then push past depth; largest bins sit at the top
        fill_done = 1'b1;
        drive(ffca_pkg::FUNC_RESTART, rand_amt());
        for (int i = 0; i < MAXB; i++)
          drive(ffca_pkg::FUNC_LOAD, (i >= MAXB - 4) ? AMT_MAX :
                ffca_pkg::AMOUNT_BITS'($urandom_range(0, 255)));
        repeat (4) drive(ffca_pkg::FUNC_LOAD, rand_amt());
        repeat (6) drive(ffca_pkg::FUNC_PLACE, AMT_MAX);
        repeat (20) drive(ffca_pkg::FUNC_PLACE, rand_amt());
      end else if (norm_cnt >= 700 && !sat_done) begin
        // run the miss count into saturation
        sat_done = 1'b1;
        drive(ffca_pkg::FUNC_RESTART, rand_amt());
        repeat (2) drive(ffca_pkg::FUNC_LOAD, '0);
        repeat (ffca_pkg::MISS_MAX + 8)
          drive(ffca_pkg::FUNC_PLACE, ffca_pkg::AMOUNT_BITS'($urandom_range(1, AMT_MAX)));
        drive(ffca_pkg::FUNC_PLACE, '0);
        drive(ffca_pkg::FUNC_PLACE, 30'd1);
      end else begin
        if ($urandom_range(0, 99) < 80) drive(ffca_pkg::FUNC_RESTART, rand_amt());
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 48);
        repeat (n) drive(ffca_pkg::FUNC_LOAD, rand_amt());
        m = $urandom_range(1, 40);
        repeat (m) begin
          r = $urandom_range(0, 99);
          if (r < 75)      drive(ffca_pkg::FUNC_PLACE, rand_amt());
          else if (r < 88) drive(ffca_pkg::FUNC_LOAD, rand_amt());
          else if (r < 92) drive(ffca_pkg::FUNC_PLACE, '0);
          else if (r < 97) drive(FUNC_NONE, rand_amt());
          else             drive(ffca_pkg::FUNC_RESTART, rand_amt());
        end
      end
    end

    in_valid_i <= 1'b0;
    while (alloc_q.size() != 0) @(posedge clk);
    repeat (MAXB + 100) @(posedge clk);
    if (errors == 0) begin
      $display("first_fit_capacity_allocator_unit verification clean");
    end else begin
      $display("first_fit_capacity_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
